// ===== sv/tftprx_pkg.sv =====
`default_nettype none

package tftprx_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int OPC_W   = 3;
    localparam int BLK_W   = 16;
    localparam int LEN_W   = 11;
    localparam int ACT_W   = 3;
    localparam int ERR_W   = 3;
    localparam int WAIT_W  = 16;
    localparam int IDLE_W  = 20;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Stream bus widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_LVL_W = $clog2(RQ_DEPTH + 1);

    // Commands
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [OPC_W-1:0] OPC_DATA = 3'd3;

    // Actions
    localparam logic [ACT_W-1:0] ACT_ACK     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ERROR   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FINISH  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FAULT   = 3'd5;

    // Unknown transfer ID
    localparam logic [ERR_W-1:0] ERR_UNKNOWN_TID = 3'd5;

    // Transfer phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ENDED  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd2;

    // Reset values of the registers
    localparam logic [WAIT_W-1:0] RST_REPLY_WAIT = 16'd2000;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT = 20'd10000;
    localparam logic [LEN_W-1:0]  RST_BLOCK_SIZE = 11'd512;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [OPC_W-1:0] opcode;
        logic [BLK_W-1:0] blk_num;
        logic             from_client;
        logic [LEN_W-1:0] payload_length;
        logic             sink_ok;
    } item_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [BLK_W-1:0] ack_block;
        logic [ERR_W-1:0] err_code;
        logic [LEN_W-1:0] write_length;
        logic             last;
    } result_t;

    function automatic result_t mk_result(input logic [ACT_W-1:0] action,
                                          input logic [BLK_W-1:0] blk,
                                          input logic [ERR_W-1:0] err,
                                          input logic [LEN_W-1:0] len);
        result_t r;
        r.action       = action;
        r.ack_block    = blk;
        r.err_code     = err;
        r.write_length = len;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tftprx_core.sv =====
`default_nettype none

module tftprx_core
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           accept,
    input  tftprx_pkg::item_t             item,
    input  wire                           cfg_we,
    input  wire [tftprx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [tftprx_pkg::CFG_DATA_W-1:0] cfg_data,
    output tftprx_pkg::result_t           res0,
    output tftprx_pkg::result_t           res1,
    output logic [1:0]                    n_res
);
    import tftprx_pkg::*;

    logic [WAIT_W-1:0]  reply_wait_reg;
    logic [IDLE_W-1:0]  idle_limit_reg;
    logic [LEN_W-1:0]   block_size_reg;

    logic [PHASE_W-1:0] phase_reg,    phase_next;
    logic [BLK_W-1:0]   expected_reg, expected_next;
    logic               final_reg,    final_next;
    logic [WAIT_W-1:0]  reply_reg,    reply_next;
    logic [IDLE_W-1:0]  idle_reg,     idle_next;

    logic [IDLE_W-1:0]  tick_idle;
    logic [WAIT_W-1:0]  tick_reply;
    logic [BLK_W-1:0]   exp_inc;
    logic               good_data;
    logic               fail_zero;
    logic               fail_cur;
    logic               fail_tick;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_wait_reg <= RST_REPLY_WAIT;
            idle_limit_reg <= RST_IDLE_LIMIT;
            block_size_reg <= RST_BLOCK_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPLY_WAIT: reply_wait_reg <= cfg_data[WAIT_W-1:0];
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data[IDLE_W-1:0];
                CFG_BLOCK_SIZE: block_size_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturating timers, next block, watchdog checks
    assign tick_idle  = (idle_reg == '1)  ? idle_reg  : idle_reg + 1'b1;
    assign tick_reply = (reply_reg == '1) ? reply_reg : reply_reg + 1'b1;
    assign exp_inc    = expected_reg + 1'b1;
    assign good_data  = (item.opcode == OPC_DATA) && (item.blk_num == exp_inc);
    assign fail_zero  = (idle_limit_reg == '0);
    assign fail_cur   = (idle_reg >= idle_limit_reg);
    assign fail_tick  = (tick_idle >= idle_limit_reg);

    // Event decode: next state and up to two results
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        final_next    = final_reg;
        reply_next    = reply_reg;
        idle_next     = idle_reg;
        res0          = '0;
        res1          = '0;
        n_res         = 2'd0;

        if (accept)
        begin
            if (item.cmd == CMD_START)
            begin
                expected_next = '0;
                final_next    = 1'b0;
                reply_next    = '0;
                idle_next     = '0;
                n_res         = 2'd1;
                if (fail_zero)
                begin
                    res0       = mk_result(ACT_TIMEOUT, '0, '0, '0);
                    phase_next = PH_ENDED;
                end
                else
                begin
                    res0       = mk_result(ACT_ACK, '0, '0, '0);
                    phase_next = PH_ACTIVE;
                end
            end
            else if (phase_reg != PH_ACTIVE || item.cmd == CMD_NONE)
            begin
                n_res = 2'd0;
            end
            else if (item.cmd == CMD_TICK)
            begin
                idle_next  = tick_idle;
                reply_next = tick_reply;
                if (tick_reply >= reply_wait_reg)
                begin
                    n_res = 2'd1;
                    if (final_reg)
                    begin
                        res0       = mk_result(ACT_FINISH, '0, '0, '0);
                        phase_next = PH_ENDED;
                    end
                    else if (fail_tick)
                    begin
                        res0       = mk_result(ACT_TIMEOUT, '0, '0, '0);
                        phase_next = PH_ENDED;
                    end
                    else
                    begin
                        res0       = mk_result(ACT_ACK, expected_reg, '0, '0);
                        reply_next = '0;
                    end
                end
            end
            else if (!item.from_client)
            begin
                // Foreign endpoint: error, then resend of the current ACK or a timeout
                n_res = 2'd2;
                res0  = mk_result(ACT_ERROR, '0, ERR_UNKNOWN_TID, '0);
                if (fail_cur)
                begin
                    res1       = mk_result(ACT_TIMEOUT, '0, '0, '0);
                    phase_next = PH_ENDED;
                end
                else
                begin
                    res1       = mk_result(ACT_ACK, expected_reg, '0, '0);
                    reply_next = '0;
                end
            end
            else if (!good_data)
            begin
                n_res = 2'd1;
                if (fail_cur)
                begin
                    res0       = mk_result(ACT_TIMEOUT, '0, '0, '0);
                    phase_next = PH_ENDED;
                end
                else
                begin
                    res0       = mk_result(ACT_ACK, expected_reg, '0, '0);
                    reply_next = '0;
                end
            end
            else
            begin
                // Expected DATA block
                idle_next = '0;
                n_res     = 2'd2;
                res0      = mk_result(ACT_WRITE, item.blk_num, '0,
                                      item.payload_length);
                if (!item.sink_ok)
                begin
                    res1       = mk_result(ACT_FAULT, item.blk_num, '0, '0);
                    phase_next = PH_ENDED;
                end
                else
                begin
                    if (item.payload_length < block_size_reg)
                        final_next = 1'b1;
                    expected_next = exp_inc;
                    if (fail_zero)
                    begin
                        res1       = mk_result(ACT_TIMEOUT, '0, '0, '0);
                        phase_next = PH_ENDED;
                    end
                    else
                    begin
                        res1       = mk_result(ACT_ACK, exp_inc, '0, '0);
                        reply_next = '0;
                    end
                end
            end
        end

        // Mark the final result of this event
        if (n_res == 2'd1)
            res0.last = 1'b1;
        if (n_res == 2'd2)
            res1.last = 1'b1;
    end

    // Transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            expected_reg <= '0;
            final_reg    <= 1'b0;
            reply_reg    <= '0;
            idle_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            final_reg    <= final_next;
            reply_reg    <= reply_next;
            idle_reg     <= idle_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tftprx_rqueue.sv =====
`default_nettype none

module tftprx_rqueue
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire [1:0]                         push_n,
    input  tftprx_pkg::result_t               in0,
    input  tftprx_pkg::result_t               in1,
    input  wire                               pop,
    output tftprx_pkg::result_t               head,
    output logic [tftprx_pkg::RQ_LVL_W-1:0]   level
);
    import tftprx_pkg::*;

    result_t              entry_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RQ_LVL_W-1:0]  level_reg,  level_next;
    logic [RQ_PTR_W-1:0]  wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign head       = entry_reg[rd_ptr_reg];
    assign level      = level_reg;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n[RQ_PTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + RQ_LVL_W'(push_n) - RQ_LVL_W'(pop);
    end

    // Result storage, one or two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[wr_ptr_reg] <= in0;
        if (push_n == 2'd2)
            entry_reg[wr_ptr_inc] <= in1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tftp_data_receiver_top.sv =====
// Receiving side of a TFTP write transfer.
// Input stream (s_*): one event per transaction. s_tuser carries the command
// (start, packet received, timer tick); s_tdata carries the packet fields.
// Output stream (m_*): one result per transaction, the action in m_tuser,
// m_tlast high on the final result caused by an event. An event yields zero,
// one or two results.
// Configuration: cfg_we/cfg_index/cfg_data write reply wait, idle limit and
// block size; write only while the block is idle.
// An event's first result is presented the cycle after it is taken if the
// queue was empty. Throughput: one event per cycle while s_tready is high;
// the output port drains one result per cycle while m_tready is high and sets
// the pace, so a two-result event takes two output transfers. A four-entry
// result queue decouples the sides; s_tready is high while at least two
// entries are free. Reset: registers return to their defaults, the transfer
// is idle and the queue is empty. When the receiver stalls, results wait in
// the queue and input is held off once fewer than two entries are free.
`default_nettype none

module tftp_data_receiver_top
(
    input  wire                               clk,
    input  wire                               rst_n,
    // Input stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [2:0] opcode, [18:3] blk_num, [19] from_client,
    // [30:20] payload_length, [31] sink_ok
    input  wire [tftprx_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  wire [tftprx_pkg::CMD_W-1:0]       s_tuser,
    // Output stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [15:0] ack_block, [18:16] err_code, [29:19] write_length, rest zero
    output logic [tftprx_pkg::M_TDATA_W-1:0]  m_tdata,
    // [2:0] action
    output logic [tftprx_pkg::ACT_W-1:0]      m_tuser,
    output logic                              m_tlast,
    // Configuration
    input  wire                               cfg_we,
    input  wire [tftprx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [tftprx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tftprx_pkg::*;

    item_t                item;
    result_t              res0;
    result_t              res1;
    result_t              head;
    logic [1:0]           n_res;
    logic [RQ_LVL_W-1:0]  level;
    logic                 s_accept;
    logic                 m_accept;

    // Handshakes
    assign s_tready = (level <= RQ_LVL_W'(RQ_DEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (level != '0);
    assign m_accept = m_tvalid && m_tready;

    // Input unpack
    assign item.cmd            = s_tuser;
    assign item.opcode         = s_tdata[2:0];
    assign item.blk_num        = s_tdata[18:3];
    assign item.from_client    = s_tdata[19];
    assign item.payload_length = s_tdata[30:20];
    assign item.sink_ok        = s_tdata[31];

    tftprx_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res0      (res0),
        .res1      (res1),
        .n_res     (n_res)
    );

    tftprx_rqueue u_rqueue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (n_res),
        .in0    (res0),
        .in1    (res1),
        .pop    (m_accept),
        .head   (head),
        .level  (level)
    );

    // Output pack
    assign m_tuser = head.action;
    assign m_tlast = head.last;
    assign m_tdata = {2'b00, head.write_length, head.err_code, head.ack_block};

`ifndef SYNTH
    // Queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= RQ_LVL_W'(RQ_DEPTH))
        else $error("result queue overfilled");

    // A start always produces a result
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser == CMD_START) |=> m_tvalid)
        else $error("start produced no result");

    // An ignored command adds nothing to an empty queue
    a_none_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser == CMD_NONE && !m_tvalid) |=> !m_tvalid)
        else $error("ignored command produced a result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tftp_data_receiver_top_tb.sv =====
module tftp_data_receiver_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tftprx_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_EVENTS = 145;
    localparam int FINAL_PACKETS = 60;

    // One row of the directed script: a register write or an event
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        item_t                 ev;
        int                    n_typed;   // -1: expectation comes from the predictor
        result_t               want0;
        result_t               want1;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [2:0] opcode, [18:3] blk_num, [19] from_client,
    // [30:20] payload_length, [31] sink_ok
    logic [S_TDATA_W-1:0]  s_tdata;
    // [1:0] cmd
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [15:0] ack_block, [18:16] err_code, [29:19] write_length
    logic [M_TDATA_W-1:0]  m_tdata;
    // [2:0] action
    logic [ACT_W-1:0]      m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state and register shadows
    logic [PHASE_W-1:0]    xfer_phase;
    logic [BLK_W-1:0]      cur_block;
    logic                  final_taken;
    logic [WAIT_W-1:0]     reply_age;
    logic [IDLE_W-1:0]     idle_age;
    logic [WAIT_W-1:0]     wait_cfg;
    logic [IDLE_W-1:0]     idle_cfg;
    logic [LEN_W-1:0]      bsize_cfg;

    result_t               awaited_results[$];
    stim_row_t             script[$];
    int                    bad_results;
    int                    cycles;
    bit                    calm;
    result_t               blank_res;

    tftp_data_receiver_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic item_t make_event(input logic [CMD_W-1:0] cmd,
                                         input logic [OPC_W-1:0] opc,
                                         input logic [BLK_W-1:0] blk,
                                         input logic             fc,
                                         input logic [LEN_W-1:0] len,
                                         input logic             ok);
        item_t e;
        e.cmd            = cmd;
        e.opcode         = opc;
        e.blk_num        = blk;
        e.from_client    = fc;
        e.payload_length = len;
        e.sink_ok        = ok;
        return e;
    endfunction

    function automatic result_t make_result(input logic [ACT_W-1:0] act,
                                            input logic [BLK_W-1:0] blk,
                                            input logic [ERR_W-1:0] err,
                                            input logic [LEN_W-1:0] len,
                                            input logic             lst);
        result_t r;
        r.action       = act;
        r.ack_block    = blk;
        r.err_code     = err;
        r.write_length = len;
        r.last         = lst;
        return r;
    endfunction

    // Watchdog check, then ACK of the current block
    function automatic result_t ack_or_timeout();
        if (idle_age >= idle_cfg)
        begin
            xfer_phase = PH_ENDED;
            return make_result(ACT_TIMEOUT, '0, '0, '0, 1'b0);
        end
        reply_age  = '0;
        xfer_phase = PH_ACTIVE;
        return make_result(ACT_ACK, cur_block, '0, '0, 1'b0);
    endfunction

    // Advances the transfer by one event; returns the number of results
    function automatic int predict_event(input item_t e, output result_t rs[2]);
        int n;
        n = 0;
        rs[0] = blank_res;
        rs[1] = blank_res;
        if (e.cmd == CMD_START)
        begin
            cur_block   = '0;
            final_taken = 1'b0;
            reply_age   = '0;
            idle_age    = '0;
            rs[0] = ack_or_timeout();
            n = 1;
        end
        else if (xfer_phase != PH_ACTIVE || e.cmd == CMD_NONE)
        begin
            n = 0;
        end
        else if (e.cmd == CMD_TICK)
        begin
            if (idle_age != '1)
                idle_age = idle_age + 1'b1;
            if (reply_age != '1)
                reply_age = reply_age + 1'b1;
            if (reply_age >= wait_cfg)
            begin
                if (final_taken)
                begin
                    rs[0] = make_result(ACT_FINISH, '0, '0, '0, 1'b0);
                    xfer_phase = PH_ENDED;
                end
                else
                begin
                    rs[0] = ack_or_timeout();
                end
                n = 1;
            end
        end
        else if (!e.from_client)
        begin
            rs[0] = make_result(ACT_ERROR, '0, ERR_UNKNOWN_TID, '0, 1'b0);
            rs[1] = ack_or_timeout();
            n = 2;
        end
        else if (e.opcode != OPC_DATA || e.blk_num != cur_block + 16'd1)
        begin
            rs[0] = ack_or_timeout();
            n = 1;
        end
        else
        begin
            idle_age = '0;
            rs[0] = make_result(ACT_WRITE, e.blk_num, '0, e.payload_length, 1'b0);
            if (!e.sink_ok)
            begin
                rs[1] = make_result(ACT_FAULT, e.blk_num, '0, '0, 1'b0);
                xfer_phase = PH_ENDED;
            end
            else
            begin
                if (e.payload_length < bsize_cfg)
                    final_taken = 1'b1;
                cur_block = cur_block + 16'd1;
                rs[1] = ack_or_timeout();
            end
            n = 2;
        end
        if (n > 0)
            rs[n-1].last = 1'b1;
        return n;
    endfunction

    // Random event, mostly the next step of a well-formed transfer
    function automatic item_t pick_event();
        item_t e;
        int    r;
        e.cmd            = CMD_W'($urandom_range(0, 3));
        e.opcode         = OPC_W'($urandom);
        e.blk_num        = BLK_W'($urandom);
        e.from_client    = 1'($urandom);
        e.payload_length = LEN_W'($urandom);
        e.sink_ok        = 1'($urandom);
        r = $urandom_range(0, 99);
        if (xfer_phase != PH_ACTIVE)
        begin
            if (r < 75)
                e.cmd = CMD_START;
            return e;
        end
        if (r < 45)
        begin
            e.cmd          = CMD_PACKET;
            e.opcode       = OPC_DATA;
            e.blk_num      = cur_block + 16'd1;
            e.from_client  = 1'b1;
            e.sink_ok      = ($urandom_range(0, 49) != 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                e.payload_length = bsize_cfg;
            else if (r < 80 && bsize_cfg != '0)
                e.payload_length = LEN_W'($urandom_range(0, bsize_cfg - 1));
        end
        else if (r < 72)
        begin
            e.cmd = CMD_TICK;
        end
        else if (r < 80)
        begin
            e.cmd         = CMD_PACKET;
            e.from_client = 1'b0;
        end
        else if (r < 88)
        begin
            // wrong opcode, or a repeat of the block already taken
            e.cmd         = CMD_PACKET;
            e.from_client = 1'b1;
            if ($urandom_range(0, 1) != 0)
            begin
                e.opcode  = OPC_DATA ^ OPC_W'($urandom_range(1, 7));
                e.blk_num = cur_block + 16'd1;
            end
            else
            begin
                e.opcode  = OPC_DATA;
                e.blk_num = cur_block;
            end
        end
        else if (r < 92)
        begin
            e.cmd = CMD_START;
        end
        else if (r < 95)
        begin
            e.cmd = CMD_NONE;
        end
        return e;
    endfunction

    task automatic note_failure(input string msg);
        bad_results++;
        if (bad_results <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic add_checked(input item_t e);
        stim_row_t row;
        row.is_write = 1'b0;
        row.reg_idx  = '0;
        row.reg_val  = '0;
        row.ev       = e;
        row.n_typed  = -1;
        row.want0    = blank_res;
        row.want1    = blank_res;
        script.push_back(row);
    endtask

    task automatic add_typed(input item_t e, input int n, input result_t a,
                             input result_t b);
        stim_row_t row;
        row.is_write = 1'b0;
        row.reg_idx  = '0;
        row.reg_val  = '0;
        row.ev       = e;
        row.n_typed  = n;
        row.want0    = a;
        row.want1    = b;
        script.push_back(row);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        row.ev       = '0;
        row.n_typed  = 0;
        row.want0    = blank_res;
        row.want1    = blank_res;
        script.push_back(row);
    endtask

    // Entered and left at a falling edge
    task automatic send_event(input item_t e, input int n_typed, input result_t w0,
                              input result_t w1);
        result_t rs[2];
        int      n;
        s_tvalid <= 1'b1;
        s_tuser  <= e.cmd;
        s_tdata  <= {e.sink_ok, e.payload_length, e.from_client, e.blk_num,
                     e.opcode};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        n = predict_event(e, rs);
        if (n_typed >= 0)
        begin
            n     = n_typed;
            rs[0] = w0;
            rs[1] = w1;
        end
        for (int k = 0; k < n; k++)
            awaited_results.push_back(rs[k]);
        @(negedge clk);
    endtask

    // Hold input off until every result is out and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_REPLY_WAIT: wait_cfg  = val[WAIT_W-1:0];
            CFG_IDLE_LIMIT: idle_cfg  = val[IDLE_W-1:0];
            CFG_BLOCK_SIZE: bsize_cfg = val[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.action       = m_tuser;
            got.ack_block    = m_tdata[15:0];
            got.err_code     = m_tdata[18:16];
            got.write_length = m_tdata[29:19];
            got.last         = m_tlast;
            if (awaited_results.size() == 0)
            begin
                note_failure($sformatf({"unexpected result act=%0d blk=%0d err=%0d ",
                                        "len=%0d last=%0d"},
                                       got.action, got.ack_block, got.err_code,
                                       got.write_length, got.last));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.action !== want.action || got.ack_block !== want.ack_block ||
                    got.err_code !== want.err_code ||
                    got.write_length !== want.write_length || got.last !== want.last)
                    note_failure($sformatf({"result mismatch: exp act=%0d blk=%0d err=%0d ",
                                            "len=%0d last=%0d, got act=%0d blk=%0d err=%0d ",
                                            "len=%0d last=%0d"},
                                           want.action, want.ack_block, want.err_code,
                                           want.write_length, want.last,
                                           got.action, got.ack_block, got.err_code,
                                           got.write_length, got.last));
            end
        end
    end

    // Output backpressure in random bursts
    initial
    begin : drive_ready
        int  run;
        bit  ready_mode;
        run = 0;
        ready_mode = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                run = 0;
                m_tready <= 1'b1;
            end
            else
            begin
                if (run == 0)
                begin
                    ready_mode = ($urandom_range(0, 2) != 0);
                    run = ready_mode ? $urandom_range(1, 20) : $urandom_range(1, 12);
                end
                run--;
                m_tready <= ready_mode;
            end
        end
    end

    // Run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tftp_data_receiver_top verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        bit prev_write;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_NONE;
        cfg_we      = 1'b0;
        cfg_index   = CFG_REPLY_WAIT;
        cfg_data    = '0;
        calm        = 1'b0;
        bad_results = 0;
        blank_res   = '0;
        prev_write  = 1'b0;
        xfer_phase  = PH_IDLE;
        cur_block   = '0;
        final_taken = 1'b0;
        reply_age   = '0;
        idle_age    = '0;
        wait_cfg    = RST_REPLY_WAIT;
        idle_cfg    = RST_IDLE_LIMIT;
        bsize_cfg   = RST_BLOCK_SIZE;

        // Default registers: events before start, a clean transfer, sink failure
        add_typed(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1), 0, blank_res, blank_res);
        add_typed(make_event(CMD_PACKET, OPC_DATA, 16'd1, 1'b1, 11'd512, 1'b1), 0,
                  blank_res, blank_res);
        add_typed(make_event(CMD_NONE, '0, '0, 1'b0, '0, 1'b0), 0, blank_res, blank_res);
        add_typed(make_event(CMD_START, '0, '0, 1'b0, '0, 1'b0), 1,
                  make_result(ACT_ACK, 16'd0, '0, '0, 1'b1), blank_res);
        add_typed(make_event(CMD_PACKET, OPC_DATA, 16'd1, 1'b0, 11'd512, 1'b1), 2,
                  make_result(ACT_ERROR, '0, ERR_UNKNOWN_TID, '0, 1'b0),
                  make_result(ACT_ACK, 16'd0, '0, '0, 1'b1));
        add_checked(make_event(CMD_PACKET, 3'd7, 16'd1, 1'b1, 11'd512, 1'b1));
        add_checked(make_event(CMD_PACKET, OPC_DATA, 16'hFFFF, 1'b1, 11'd512, 1'b1));
        add_typed(make_event(CMD_PACKET, OPC_DATA, 16'd1, 1'b1, 11'd512, 1'b1), 2,
                  make_result(ACT_WRITE, 16'd1, '0, 11'd512, 1'b0),
                  make_result(ACT_ACK, 16'd1, '0, '0, 1'b1));
        add_checked(make_event(CMD_PACKET, OPC_DATA, 16'd2, 1'b1, 11'd1024, 1'b1));
        // oversized payload passes through
        add_checked(make_event(CMD_PACKET, OPC_DATA, 16'd3, 1'b1, 11'd2047, 1'b1));
        add_checked(make_event(CMD_PACKET, OPC_DATA, 16'd4, 1'b1, 11'd0, 1'b1));
        add_typed(make_event(CMD_NONE, '0, '0, 1'b1, '0, 1'b1), 0, blank_res, blank_res);
        add_typed(make_event(CMD_PACKET, OPC_DATA, 16'd5, 1'b1, 11'd100, 1'b0), 2,
                  make_result(ACT_WRITE, 16'd5, '0, 11'd100, 1'b0),
                  make_result(ACT_FAULT, 16'd5, '0, '0, 1'b1));
        add_typed(make_event(CMD_PACKET, OPC_DATA, 16'd6, 1'b1, 11'd8, 1'b1), 0,
                  blank_res, blank_res);
        add_typed(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1), 0, blank_res, blank_res);
        // Zero registers: watchdog fails at once
        add_write(CFG_IDLE_LIMIT, '0);
        add_write(CFG_REPLY_WAIT, '0);
        add_write(CFG_BLOCK_SIZE, '0);
        add_typed(make_event(CMD_START, '0, '0, 1'b1, '0, 1'b1), 1,
                  make_result(ACT_TIMEOUT, '0, '0, '0, 1'b1), blank_res);
        // Zero reply wait and block size, short watchdog
        add_write(CFG_IDLE_LIMIT, 20'd3);
        add_checked(make_event(CMD_START, '0, '0, 1'b1, '0, 1'b1));
        add_checked(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1));
        add_checked(make_event(CMD_PACKET, OPC_DATA, 16'd1, 1'b1, 11'd0, 1'b1));
        repeat (3) add_checked(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1));
        // Largest block size and watchdog; short block, then finish on reply wait
        add_write(CFG_BLOCK_SIZE, 20'd2047);
        add_write(CFG_IDLE_LIMIT, 20'hFFFFF);
        add_write(CFG_REPLY_WAIT, 20'd1);
        add_checked(make_event(CMD_START, '0, '0, 1'b1, '0, 1'b1));
        add_checked(make_event(CMD_PACKET, OPC_DATA, 16'd1, 1'b1, 11'd2046, 1'b1));
        add_typed(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1), 1,
                  make_result(ACT_FINISH, '0, '0, '0, 1'b1), blank_res);
        add_checked(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1));

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed script
        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                if (!prev_write)
                    settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                send_event(script[i].ev, script[i].n_typed, script[i].want0,
                           script[i].want1);
            end
            prev_write = script[i].is_write;
        end

        // Random phases, each with fresh register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_REPLY_WAIT, '0);
                1:       write_reg(CFG_REPLY_WAIT, 20'hFFFF);
                2:       write_reg(CFG_REPLY_WAIT, 20'd1);
                default: write_reg(CFG_REPLY_WAIT, CFG_DATA_W'($urandom_range(2, 12)));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_IDLE_LIMIT, '0);
                1:       write_reg(CFG_IDLE_LIMIT, 20'hFFFFF);
                default: write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'($urandom_range(3, 80)));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_BLOCK_SIZE, '0);
                1:       write_reg(CFG_BLOCK_SIZE, 20'd2047);
                2:       write_reg(CFG_BLOCK_SIZE, 20'd8);
                3:       write_reg(CFG_BLOCK_SIZE, 20'd1024);
                default: write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'($urandom_range(8, 64)));
            endcase
            for (int i = 0; i < PHASE_EVENTS; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
                else if ($urandom_range(0, 99) == 0)
                begin
                    settle();
                end
                send_event(pick_event(), -1, blank_res, blank_res);
            end
        end

        // Long data run at full rate, no idling on either side
        settle();
        calm = 1'b1;
        write_reg(CFG_REPLY_WAIT, 20'hFFFF);
        write_reg(CFG_IDLE_LIMIT, 20'hFFFFF);
        write_reg(CFG_BLOCK_SIZE, 20'd1024);
        send_event(make_event(CMD_START, '0, '0, 1'b1, '0, 1'b1), -1, blank_res, blank_res);
        for (int i = 0; i < FINAL_PACKETS; i++)
            send_event(make_event(CMD_PACKET, OPC_DATA, cur_block + 16'd1, 1'b1,
                                  LEN_W'($urandom_range(1024, 2047)), 1'b1),
                       -1, blank_res, blank_res);
        send_event(make_event(CMD_PACKET, OPC_DATA, cur_block + 16'd1, 1'b1, 11'd10, 1'b1),
                   -1, blank_res, blank_res);
        repeat (3) send_event(make_event(CMD_TICK, '0, '0, 1'b1, '0, 1'b1),
                              -1, blank_res, blank_res);

        // Drain and finish
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (bad_results == 0 && awaited_results.size() == 0)
            $display("tftp_data_receiver_top verification clean");
        else
            $display("tftp_data_receiver_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tftprx_pkg.sv
sv/tftprx_core.sv
sv/tftprx_rqueue.sv
sv/tftp_data_receiver_top.sv
tb/sv/tftp_data_receiver_top_tb.sv
